FILE: src/dis_pkg.sv
// ----------------------------------------------------------------------------
// dis_pkg
// Shared types and constants for the disjoint interval set: the per-item
// action code, the control group that drives the cell row, and the status
// each cell reports back.
// ----------------------------------------------------------------------------
package dis_pkg;

  // Default sizing of the interval store.
  localparam int DEF_VALUE_WIDTH   = 14;
  localparam int DEF_MAX_INTERVALS = 64;

  // Cells per first-level group of the result gather tree.
  localparam int GATHER_GROUP = 8;

  // What the cell row does with the current item.
  typedef enum logic [2:0] {
    ACT_READ,
    ACT_DUP,
    ACT_MERGE,
    ACT_LEFT,
    ACT_RIGHT,
    ACT_INSERT,
    ACT_DROP
  } act_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load;   // capture compare flags against the item value
    logic apply;  // perform the action and mark the result cell
    act_t action;
  } cell_ctrl_t;

  // Status a cell reports from its captured flags.
  typedef struct packed {
    logic cov;        // the cell's interval already covers the value
    logic left_adj;   // cell sits just below the value and ends one short
    logic right_adj;  // cell sits just above the value and starts one past
  } cell_stat_t;

endpackage

FILE: src/disjoint_interval_set_top.sv
// ----------------------------------------------------------------------------
// disjoint_interval_set_top
// Sorted set of disjoint closed intervals held in a row of compare-and-shift
// cells, with add-value and read-interval commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high while busy is low. Every command
// returns exactly one result, shown for a single cycle with done high;
// busy stays high from the accepting edge until the result shows, so the
// block takes no new command until the last one has its result. After the
// accepting edge the sequencer passes through a compare state, where every
// cell compares its interval with the value in parallel, an update state,
// where the row extends, merges, shifts or loads in a single step, a state
// for the registered first level of the OR tree that pulls the chosen
// interval out of the row, and one for its second level feeding the output
// register. The receiver cannot stall and must take each result in the
// cycle it is shown. After reset the set is empty and the block is ready
// at once.
// ----------------------------------------------------------------------------
module disjoint_interval_set_top #(
  parameter int VALUE_WIDTH   = dis_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_INTERVALS = dis_pkg::DEF_MAX_INTERVALS,
  localparam int IdxWidth     = $clog2(MAX_INTERVALS),
  localparam int CntWidth     = $clog2(MAX_INTERVALS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   operation,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [IdxWidth-1:0]    index,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] interval_start,
  output logic [VALUE_WIDTH-1:0] interval_end,
  output logic [CntWidth-1:0]    interval_count,
  output logic                   entry_valid,
  output logic                   was_duplicate,
  output logic                   overflow
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_GATH,
    ST_EMIT
  } state_t;

  state_t                  state;
  logic [CntWidth-1:0]     count;
  logic [CntWidth-1:0]     count_next;
  logic                    op_q;
  logic [VALUE_WIDTH-1:0]  value_q;
  logic [IdxWidth-1:0]     index_q;
  logic                    valid_q;
  logic                    dup_q;
  logic                    ovf_q;

  dis_pkg::cell_ctrl_t     ctrl;
  dis_pkg::act_t           action;
  logic                    any_cov;
  logic                    any_left;
  logic                    any_right;

  logic [MAX_INTERVALS-1:0]                  cell_le;
  logic [MAX_INTERVALS-1:0]                  cell_occ;
  logic [MAX_INTERVALS-1:0]                  cell_rd;
  logic [MAX_INTERVALS-1:0][VALUE_WIDTH-1:0] cell_start;
  logic [MAX_INTERVALS-1:0][VALUE_WIDTH-1:0] cell_end;
  dis_pkg::cell_stat_t [MAX_INTERVALS-1:0]   cell_stat;
  logic [MAX_INTERVALS-1:0][2*VALUE_WIDTH-1:0] cell_word;
  logic [2*VALUE_WIDTH-1:0]                  gathered;

  // Occupancy and read match per cell from the count and latched index.
  always_comb begin
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      cell_occ[i] = CntWidth'(i) < count;
      cell_rd[i]  = index_q == IdxWidth'(i);
    end
  end

  // The row of cells, each wired to its two neighbors.
  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    logic                   le_prev;
    logic                   le_next;
    logic [VALUE_WIDTH-1:0] start_prev;
    logic [VALUE_WIDTH-1:0] end_prev;
    logic [VALUE_WIDTH-1:0] start_next;
    logic [VALUE_WIDTH-1:0] end_next;

    if (i == 0) begin : g_first
      assign le_prev    = 1'b1;
      assign start_prev = cell_start[i];
      assign end_prev   = cell_end[i];
    end else begin : g_inner_prev
      assign le_prev    = cell_le[i-1];
      assign start_prev = cell_start[i-1];
      assign end_prev   = cell_end[i-1];
    end

    if (i == MAX_INTERVALS - 1) begin : g_last
      assign le_next    = 1'b0;
      assign start_next = cell_start[i];
      assign end_next   = cell_end[i];
    end else begin : g_inner_next
      assign le_next    = cell_le[i+1];
      assign start_next = cell_start[i+1];
      assign end_next   = cell_end[i+1];
    end

    dis_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .value      (value_q),
      .occupied   (cell_occ[i]),
      .rd_hit     (cell_rd[i]),
      .le_prev    (le_prev),
      .le_next    (le_next),
      .start_prev (start_prev),
      .end_prev   (end_prev),
      .start_next (start_next),
      .end_next   (end_next),
      .le         (cell_le[i]),
      .start_val  (cell_start[i]),
      .end_val    (cell_end[i]),
      .stat       (cell_stat[i]),
      .sel_start  (cell_word[i][2*VALUE_WIDTH-1:VALUE_WIDTH]),
      .sel_end    (cell_word[i][VALUE_WIDTH-1:0])
    );
  end

  // Result gather tree.
  dis_gather #(
    .NUM_CELLS  (MAX_INTERVALS),
    .WORD_WIDTH (2 * VALUE_WIDTH)
  ) u_gather (
    .clk       (clk),
    .cell_word (cell_word),
    .word      (gathered)
  );

  // Row-wide status from the captured cell flags.
  always_comb begin
    any_cov   = 1'b0;
    any_left  = 1'b0;
    any_right = 1'b0;
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      any_cov   = any_cov   | cell_stat[i].cov;
      any_left  = any_left  | cell_stat[i].left_adj;
      any_right = any_right | cell_stat[i].right_adj;
    end
  end

  // Action choice and the count that follows from it.
  always_comb begin
    if (op_q) begin
      action = dis_pkg::ACT_READ;
    end else if (any_cov) begin
      action = dis_pkg::ACT_DUP;
    end else if (any_left && any_right) begin
      action = dis_pkg::ACT_MERGE;
    end else if (any_left) begin
      action = dis_pkg::ACT_LEFT;
    end else if (any_right) begin
      action = dis_pkg::ACT_RIGHT;
    end else if (count == CntWidth'(MAX_INTERVALS)) begin
      action = dis_pkg::ACT_DROP;
    end else begin
      action = dis_pkg::ACT_INSERT;
    end

    case (action)
      dis_pkg::ACT_MERGE:  count_next = count - CntWidth'(1);
      dis_pkg::ACT_INSERT: count_next = count + CntWidth'(1);
      default:             count_next = count;
    endcase

    ctrl.load   = state == ST_CMP;
    ctrl.apply  = state == ST_UPD;
    ctrl.action = action;
  end

  assign busy = state != ST_IDLE;

  // Sequencer with the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op_q    <= operation;
            value_q <= value;
            index_q <= index;
            state   <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          count   <= count_next;
          dup_q   <= action == dis_pkg::ACT_DUP;
          ovf_q   <= action == dis_pkg::ACT_DROP;
          valid_q <= op_q ? (CntWidth'(index_q) < count) : (action != dis_pkg::ACT_DROP);
          state   <= ST_GATH;
        end
        ST_GATH: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          interval_start <= gathered[2*VALUE_WIDTH-1:VALUE_WIDTH];
          interval_end   <= gathered[VALUE_WIDTH-1:0];
          interval_count <= count;
          entry_valid    <= valid_q;
          was_duplicate  <= dup_q;
          overflow       <= ovf_q;
          done           <= 1'b1;
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // A result appears only once the sequencer is ready for the next command.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while the block is still busy");

  // An accepted command keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  // The count never exceeds the number of cells.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= CntWidth'(MAX_INTERVALS))
    else $error("interval count exceeds the cell row");

  // A dropped add only happens with every cell occupied.
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
      (done && overflow) |-> (interval_count == CntWidth'(MAX_INTERVALS) && !entry_valid))
    else $error("overflow reported with free cells");
`endif

endmodule

FILE: src/dis_cell.sv
// ----------------------------------------------------------------------------
// dis_cell
// One slot of the sorted interval row. Compares its interval with the item
// value, talks to its neighbors to find the insertion point, and shifts,
// extends or loads its interval when the sequencer applies an action.
// ----------------------------------------------------------------------------
module dis_cell #(
  parameter int VALUE_WIDTH = dis_pkg::DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  dis_pkg::cell_ctrl_t    ctrl,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   occupied,
  input  logic                   rd_hit,
  input  logic                   le_prev,
  input  logic                   le_next,
  input  logic [VALUE_WIDTH-1:0] start_prev,
  input  logic [VALUE_WIDTH-1:0] end_prev,
  input  logic [VALUE_WIDTH-1:0] start_next,
  input  logic [VALUE_WIDTH-1:0] end_next,
  output logic                   le,
  output logic [VALUE_WIDTH-1:0] start_val,
  output logic [VALUE_WIDTH-1:0] end_val,
  output dis_pkg::cell_stat_t    stat,
  output logic [VALUE_WIDTH-1:0] sel_start,
  output logic [VALUE_WIDTH-1:0] sel_end
);

  logic [VALUE_WIDTH-1:0] start_r;
  logic [VALUE_WIDTH-1:0] end_r;
  logic                   le_r;
  logic                   cov_r;
  logic                   ladj_r;
  logic                   radj_r;
  logic                   sel_r;

  logic                   at_p;
  logic                   is_left;
  logic                   beyond_p;
  logic                   le_now;
  logic                   cov_now;
  logic                   ladj_now;
  logic                   radj_now;

  // Compare flags against the item value; one bit of headroom avoids wrap.
  always_comb begin
    le_now   = occupied && (start_r <= value);
    cov_now  = le_now && (end_r >= value);
    ladj_now = occupied && (({1'b0, end_r} + 1'b1) == {1'b0, value});
    radj_now = occupied && ({1'b0, start_r} == ({1'b0, value} + 1'b1));
  end

  // Position of this cell relative to the insertion point p.
  always_comb begin
    at_p     = !le_r && le_prev;
    is_left  = le_r && !le_next;
    beyond_p = !le_r && !le_prev;
  end

  // Flag capture, then the action on the interval and the result mark.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      le_r   <= le_now;
      cov_r  <= cov_now;
      ladj_r <= ladj_now;
      radj_r <= radj_now;
    end
    if (ctrl.apply) begin
      unique case (ctrl.action)
        dis_pkg::ACT_MERGE: begin
          if (is_left) begin
            end_r <= end_next;
          end else if (!le_r) begin
            start_r <= start_next;
            end_r   <= end_next;
          end
          sel_r <= is_left;
        end
        dis_pkg::ACT_LEFT: begin
          if (is_left) begin
            end_r <= value;
          end
          sel_r <= is_left;
        end
        dis_pkg::ACT_RIGHT: begin
          if (at_p) begin
            start_r <= value;
          end
          sel_r <= at_p;
        end
        dis_pkg::ACT_INSERT: begin
          if (at_p) begin
            start_r <= value;
            end_r   <= value;
          end else if (beyond_p) begin
            start_r <= start_prev;
            end_r   <= end_prev;
          end
          sel_r <= at_p;
        end
        dis_pkg::ACT_DUP: begin
          sel_r <= cov_r;
        end
        dis_pkg::ACT_READ: begin
          sel_r <= rd_hit && occupied;
        end
        dis_pkg::ACT_DROP: begin
          sel_r <= 1'b0;
        end
        default: begin
          sel_r <= 1'b0;
        end
      endcase
    end
  end

  // Neighbor and sequencer outputs.
  assign le             = le_r;
  assign start_val      = start_r;
  assign end_val        = end_r;
  assign stat.cov       = cov_r;
  assign stat.left_adj  = ladj_r && is_left;
  assign stat.right_adj = radj_r && at_p;
  assign sel_start      = sel_r ? start_r : '0;
  assign sel_end        = sel_r ? end_r : '0;

endmodule

FILE: src/dis_gather.sv
// ----------------------------------------------------------------------------
// dis_gather
// Two-level OR tree that collects the one marked interval from the cell row.
// The first level ORs fixed groups of cells into registers; the second level
// ORs the group registers combinationally.
// ----------------------------------------------------------------------------
module dis_gather #(
  parameter int NUM_CELLS  = dis_pkg::DEF_MAX_INTERVALS,
  parameter int WORD_WIDTH = 2 * dis_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                 clk,
  input  logic [NUM_CELLS-1:0][WORD_WIDTH-1:0] cell_word,
  output logic [WORD_WIDTH-1:0]                word
);

  localparam int NumGroups = (NUM_CELLS + dis_pkg::GATHER_GROUP - 1) / dis_pkg::GATHER_GROUP;

  logic [NumGroups-1:0][WORD_WIDTH-1:0] group_or;
  logic [NumGroups-1:0][WORD_WIDTH-1:0] group_next;

  // First level: OR within each group of cells.
  always_comb begin
    group_next = '0;
    for (int g = 0; g < NumGroups; g++) begin
      for (int k = 0; k < dis_pkg::GATHER_GROUP; k++) begin
        if (g * dis_pkg::GATHER_GROUP + k < NUM_CELLS) begin
          group_next[g] = group_next[g] | cell_word[g * dis_pkg::GATHER_GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    group_or <= group_next;
  end

  // Second level: OR across the group registers.
  always_comb begin
    word = '0;
    for (int g = 0; g < NumGroups; g++) begin
      word = word | group_or[g];
    end
  end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the disjoint interval set. Add and read commands
// go in through the start/busy handshake. A bench-side copy of the interval
// list predicts every result, and each result shown with done is compared
// field by field against the oldest prediction still pending.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW          = dis_pkg::DEF_VALUE_WIDTH;
  localparam int MAXN        = dis_pkg::DEF_MAX_INTERVALS;
  localparam int IW          = $clog2(MAXN);
  localparam int CW          = $clog2(MAXN + 1);
  localparam int VALUE_SPAN  = 1 << VW;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 10;

  // Command codes carried on the operation port.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // One result as the block reports it.
  typedef struct packed {
    logic [VW-1:0] lo;
    logic [VW-1:0] hi;
    logic [CW-1:0] count;
    logic          valid;
    logic          dup;
    logic          ovf;
  } interval_result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          operation = OP_ADD;
  logic [VW-1:0] value = '0;
  logic [IW-1:0] index = '0;
  logic          busy;
  logic          done;
  logic [VW-1:0] interval_start;
  logic [VW-1:0] interval_end;
  logic [CW-1:0] interval_count;
  logic          entry_valid;
  logic          was_duplicate;
  logic          overflow;

  // Bench copy of the interval list.
  logic [VW-1:0] span_lo [MAXN];
  logic [VW-1:0] span_hi [MAXN];
  int            span_count = 0;

  interval_result_t pending_results [$];

  int idle_pct       = 0;
  int err_count      = 0;
  int cycle_count    = 0;
  int results_seen   = 0;
  int n_adds         = 0;
  int n_reads        = 0;
  int n_dups         = 0;
  int n_merges       = 0;
  int n_drops        = 0;
  int peak_count     = 0;

  disjoint_interval_set_top u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .value          (value),
    .index          (index),
    .done           (done),
    .interval_start (interval_start),
    .interval_end   (interval_end),
    .interval_count (interval_count),
    .entry_valid    (entry_valid),
    .was_duplicate  (was_duplicate),
    .overflow       (overflow)
  );

  always #4 clk = ~clk;

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Applies one command to the bench interval list and returns its result.
  function automatic interval_result_t update_interval_set(logic op, logic [VW-1:0] v_in,
                                                           logic [IW-1:0] idx);
    interval_result_t r;
    int n, p, v, i;
    bit left_adj, right_adj;
    r = '0;
    n = span_count;
    v = int'(v_in);
    if (op == OP_READ) begin
      n_reads++;
      if (int'(idx) < n) begin
        r.lo    = span_lo[idx];
        r.hi    = span_hi[idx];
        r.valid = 1'b1;
      end
    end else begin
      n_adds++;
      // First interval starting above the value.
      p = 0;
      while (p < n && int'(span_lo[p]) <= v) p++;
      left_adj  = (p > 0) && (int'(span_hi[p-1]) + 1 == v);
      right_adj = (p < n) && (int'(span_lo[p]) == v + 1);
      if (p > 0 && int'(span_hi[p-1]) >= v) begin
        n_dups++;
        r.lo = span_lo[p-1];
        r.hi = span_hi[p-1];
        r.valid = 1'b1;
        r.dup   = 1'b1;
      end else if (left_adj && right_adj) begin
        // The value fills the one-wide gap: fold the upper interval in.
        n_merges++;
        span_hi[p-1] = span_hi[p];
        for (i = p; i + 1 < n; i++) begin
          span_lo[i] = span_lo[i+1];
          span_hi[i] = span_hi[i+1];
        end
        span_count = n - 1;
        r.lo = span_lo[p-1];
        r.hi = span_hi[p-1];
        r.valid = 1'b1;
      end else if (left_adj) begin
        span_hi[p-1] = v_in;
        r.lo = span_lo[p-1];
        r.hi = span_hi[p-1];
        r.valid = 1'b1;
      end else if (right_adj) begin
        span_lo[p] = v_in;
        r.lo = span_lo[p];
        r.hi = span_hi[p];
        r.valid = 1'b1;
      end else if (n >= MAXN) begin
        n_drops++;
        r.ovf = 1'b1;
      end else begin
        for (i = n; i > p; i--) begin
          span_lo[i] = span_lo[i-1];
          span_hi[i] = span_hi[i-1];
        end
        span_lo[p] = v_in;
        span_hi[p] = v_in;
        span_count = n + 1;
        r.lo = v_in;
        r.hi = v_in;
        r.valid = 1'b1;
      end
    end
    r.count = CW'(span_count);
    if (span_count > peak_count) peak_count = span_count;
    return r;
  endfunction

  // Presents one command, waits until the block is no longer busy, and queues its predicted result.
  // Start is left high so a back-to-back command is taken as soon as busy is low.
  task automatic send_item(logic op, logic [VW-1:0] v, logic [IW-1:0] idx);
    if ($urandom_range(0, 99) < idle_pct) begin
      start     <= 1'b0;
      operation <= 1'($urandom);
      value     <= VW'($urandom);
      index     <= IW'($urandom);
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start     <= 1'b1;
    operation <= op;
    value     <= v;
    index     <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results = {pending_results, update_interval_set(op, v, idx)};
  endtask

  // Holds off new commands until every pending result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Reads on the empty set, first and last index.
  task automatic test_empty_set();
    idle_pct = 0;
    send_item(OP_READ, '0, '0);
    send_item(OP_READ, '1, IW'(MAXN - 1));
  endtask

  // Insert, duplicate, extension on each side, merge, and the value extremes.
  task automatic test_add_cases();
    send_item(OP_ADD, VW'(100), '0);
    send_item(OP_ADD, VW'(100), '0);
    send_item(OP_ADD, VW'(101), '0);
    send_item(OP_ADD, VW'(99), '0);
    send_item(OP_ADD, VW'(103), '0);
    send_item(OP_ADD, VW'(102), '0);
    send_item(OP_ADD, VW'(101), '0);
    send_item(OP_ADD, '0, '0);
    send_item(OP_ADD, '1, '0);
    send_item(OP_ADD, VW'(1), '0);
    send_item(OP_ADD, VW'(VALUE_SPAN - 2), '0);
    send_item(OP_ADD, VW'(14'h2AAA), '0);
    send_item(OP_ADD, VW'(14'h1555), '0);
  endtask

  // Reads at valid positions, at the count, and past it.
  task automatic test_reads();
    send_item(OP_READ, '0, '0);
    send_item(OP_READ, '0, IW'(span_count - 1));
    send_item(OP_READ, '1, IW'(span_count));
    send_item(OP_READ, '0, IW'(MAXN - 1));
    send_item(OP_READ, '0, IW'(6'h2A));
    send_item(OP_READ, '1, IW'(6'h15));
    send_item(OP_READ, '0, IW'(2));
  endtask

  // Dense bursts of adds in small windows so that extensions and merges
  // dominate, mixed with reads and a few adds scattered over the full range.
  task automatic test_random_traffic(int n_items, int pct);
    int base, width, left, roll, k;
    idle_pct = pct;
    left = 0;
    repeat (n_items) begin
      if (left == 0) begin
        width = $urandom_range(4, 16);
        if (span_count >= 48) begin
          // Near capacity: work next to a stored interval so adds still land.
          k = $urandom_range(0, span_count - 1);
          base = int'(span_hi[k]) - 2;
        end else begin
          base = $urandom_range(0, VALUE_SPAN - 1);
        end
        if (base < 0) base = 0;
        if (base > VALUE_SPAN - width) base = VALUE_SPAN - width;
        left = 2 * width;
      end
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        send_item(OP_READ, VW'($urandom), IW'($urandom_range(0, MAXN - 1)));
      end else if (roll < 30) begin
        send_item(OP_READ, VW'($urandom), IW'($urandom_range(0, span_count)));
      end else if (roll < 33) begin
        send_item(OP_ADD, VW'($urandom), IW'($urandom));
      end else begin
        send_item(OP_ADD, VW'(base + $urandom_range(0, width - 1)), IW'($urandom));
        left--;
      end
    end
  endtask

  // Fills the store, then checks a dropped add and that extension and
  // merging still succeed while it is full.
  task automatic test_full_store();
    int v, k, gap, best_k, best_gap, lo_b, hi_b, isolated;
    idle_pct = 0;
    v = $urandom_range(0, VALUE_SPAN - 1);
    while (span_count < MAXN) begin
      send_item(OP_ADD, VW'(v), IW'($urandom));
      v = (v + 3) % VALUE_SPAN;
    end
    // A value with no neighbor in the set needs a new entry and is dropped.
    isolated = -1;
    lo_b = -1;
    for (k = 0; k <= MAXN && isolated < 0; k++) begin
      hi_b = (k == MAXN) ? VALUE_SPAN : int'(span_lo[k]);
      if (hi_b - lo_b >= 4) isolated = lo_b + 2;
      if (k < MAXN) lo_b = int'(span_hi[k]);
    end
    if (isolated >= 0) send_item(OP_ADD, VW'(isolated), '0);
    send_item(OP_READ, '0, IW'(MAXN - 1));
    // Close the narrowest gap from both sides until the two intervals merge.
    best_gap = VALUE_SPAN;
    best_k = 0;
    for (k = 0; k < MAXN - 1; k++) begin
      gap = int'(span_lo[k+1]) - int'(span_hi[k]);
      if (gap < best_gap) begin
        best_gap = gap;
        best_k = k;
      end
    end
    if (best_gap >= 3) send_item(OP_ADD, VW'(int'(span_lo[best_k+1]) - 1), '0);
    while (span_count == MAXN) send_item(OP_ADD, VW'(int'(span_hi[best_k]) + 1), '0);
    send_item(OP_READ, '0, IW'(best_k));
    send_item(OP_READ, '0, IW'(MAXN - 1));
  endtask

  // Compares each result against the oldest pending prediction.
  always @(posedge clk) begin : check_results
    interval_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, interval_count", interval_count, 0);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (interval_start !== want.lo)
          report_mismatch("interval_start", interval_start, want.lo);
        if (interval_end !== want.hi)
          report_mismatch("interval_end", interval_end, want.hi);
        if (interval_count !== want.count)
          report_mismatch("interval_count", interval_count, want.count);
        if (entry_valid !== want.valid)
          report_mismatch("entry_valid", entry_valid, want.valid);
        if (was_duplicate !== want.dup)
          report_mismatch("was_duplicate", was_duplicate, want.dup);
        if (overflow !== want.ovf)
          report_mismatch("overflow", overflow, want.ovf);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_set();
    test_add_cases();
    test_reads();
    wait_drained();
    test_random_traffic(400, 0);
    wait_drained();
    test_random_traffic(400, 50);
    wait_drained();
    test_random_traffic(400, 24);
    wait_drained();
    test_full_store();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d adds (%0d duplicates, %0d merges, %0d dropped), %0d reads.",
             results_seen, n_adds, n_dups, n_merges, n_drops, n_reads);
    $display("Sender gaps of 0, 50 and 24 percent; the set held up to %0d intervals.",
             peak_count);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
